// ===== hdl/mrrc_pkg.sv =====
// Types, constants and the CRC-16/MODBUS byte update for the Modbus RTU
// read response checker. No dependencies.
`timescale 1ns / 1ps

package mrrc_pkg;

    localparam int CapDepth = 13;
    localparam int RegSlots = 5;
    localparam int CountWidth = 8;
    localparam logic [7:0] FuncRead = 8'h03;
    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'hA001;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_FRAME_END = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK = 2'd0,
        STAT_CRC_ERR = 2'd1,
        STAT_NO_MATCH = 2'd2,
        STAT_SHORT = 2'd3
    } status_t;

    typedef logic [CapDepth-1:0][7:0] capture_t;

    typedef struct packed {
        logic [CountWidth-1:0] count;
        logic [15:0] crc;
        logic [7:0] dly0;
        logic [7:0] dly1;
    } frame_t;

    typedef struct packed {
        status_t status;
        logic load;
    } check_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CrcPoly;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== hdl/mrrc_in_if.sv =====
// Input channel: one received byte or frame-end word per handshake.
// Depends on nothing.
`timescale 1ns / 1ps

interface mrrc_in_if;
    logic valid;
    logic ready;
    logic command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink (input valid, input command, input rx_byte, output ready);
endinterface

// ===== hdl/mrrc_out_if.sv =====
// Result channel: one checked-frame word per handshake.
// Depends on nothing.
`timescale 1ns / 1ps

interface mrrc_out_if;
    logic valid;
    logic ready;
    logic [1:0] status;
    logic [7:0] frame_length;
    logic [15:0] reg_zero;
    logic [15:0] reg_one;
    logic [15:0] reg_two;
    logic [15:0] reg_three;
    logic [15:0] reg_four;

    modport source (output valid, output status, output frame_length, output reg_zero,
                    output reg_one, output reg_two, output reg_three, output reg_four,
                    input ready);
    modport sink (input valid, input status, input frame_length, input reg_zero,
                  input reg_one, input reg_two, input reg_three, input reg_four,
                  output ready);
endinterface

// ===== hdl/mrrc_frame_acc.sv =====
// Frame accumulator: byte count, capture of the leading bytes, two-byte
// delay line and running CRC. Depends on mrrc_pkg.
`timescale 1ns / 1ps

module mrrc_frame_acc #(
    parameter int MAX_FRAME = 255
) (
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  logic command,
    input  logic [7:0] rx_byte,
    output mrrc_pkg::frame_t frame,
    output mrrc_pkg::capture_t capture
);

    localparam logic [mrrc_pkg::CountWidth-1:0] MaxCount = mrrc_pkg::CountWidth'(MAX_FRAME);

    mrrc_pkg::frame_t frame_reg;
    mrrc_pkg::frame_t frame_next;
    mrrc_pkg::capture_t capture_reg;
    mrrc_pkg::capture_t capture_next;

    always_comb
    begin
        frame_next = frame_reg;
        capture_next = capture_reg;
        if (accept)
        begin
            if (command == mrrc_pkg::CMD_FRAME_END)
            begin
                frame_next.count = '0;
                frame_next.crc = mrrc_pkg::CrcInit;
                frame_next.dly0 = '0;
                frame_next.dly1 = '0;
            end
            else if (frame_reg.count < MaxCount)
            begin
                for (int i = 0; i < mrrc_pkg::CapDepth; i++)
                begin
                    if (frame_reg.count == mrrc_pkg::CountWidth'(i))
                        capture_next[i] = rx_byte;
                end
                if (frame_reg.count >= mrrc_pkg::CountWidth'(2))
                    frame_next.crc = mrrc_pkg::crc_byte(frame_reg.crc, frame_reg.dly0);
                frame_next.dly0 = frame_reg.dly1;
                frame_next.dly1 = rx_byte;
                frame_next.count = frame_reg.count + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg.count <= '0;
            frame_reg.crc <= mrrc_pkg::CrcInit;
            frame_reg.dly0 <= '0;
            frame_reg.dly1 <= '0;
            capture_reg <= '0;
        end
        else
        begin
            frame_reg <= frame_next;
            capture_reg <= capture_next;
        end
    end

    assign frame = frame_reg;
    assign capture = capture_reg;

endmodule

// ===== hdl/mrrc_check.sv =====
// Frame-end check: length, CRC against the delayed bytes, address and
// function code. Depends on mrrc_pkg.
`timescale 1ns / 1ps

module mrrc_check (
    input  mrrc_pkg::frame_t frame,
    input  mrrc_pkg::capture_t capture,
    input  logic [7:0] slave_address,
    output mrrc_pkg::check_t result
);

    logic [15:0] got_crc;

    assign got_crc = {frame.dly1, frame.dly0};

    always_comb
    begin
        result.load = 1'b0;
        if (frame.count < mrrc_pkg::CountWidth'(2))
            result.status = mrrc_pkg::STAT_SHORT;
        else if (got_crc != frame.crc)
            result.status = mrrc_pkg::STAT_CRC_ERR;
        else if (capture[1] == mrrc_pkg::FuncRead && capture[0] == slave_address)
        begin
            result.status = mrrc_pkg::STAT_OK;
            result.load = 1'b1;
        end
        else
            result.status = mrrc_pkg::STAT_NO_MATCH;
    end

endmodule

// ===== hdl/modbus_rtu_read_response_checker_core.sv =====
// Top level of the Modbus RTU read response checker: config register,
// held registers and result register. Depends on mrrc_pkg, mrrc_in_if,
// mrrc_out_if, mrrc_frame_acc and mrrc_check.
//
//   channel    dir  word                                  accepted when
//   rx_words   in   command, rx_byte                      valid & ready
//   results    out  status, frame_length, reg_zero..four  valid & ready
//   cfg        in   cfg_data (slave address)              cfg_write
//
// One word per cycle while rx_words.ready is high; a byte updates count,
// capture and CRC in the cycle it is taken, a frame end loads the result
// register when taken. Bytes give no result. rx_words.ready drops only while
// a result waits and results.ready is low. Reset clears all frame state at once.
`timescale 1ns / 1ps

module modbus_rtu_read_response_checker_core #(
    parameter int MAX_FRAME = 255,
    parameter int NUM_REGS = 5
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write,
    input  logic [7:0] cfg_data,
    mrrc_in_if.sink rx_words,
    mrrc_out_if.source results
);

    logic [7:0] slave_address_reg;
    logic in_accept;
    logic frame_end;
    mrrc_pkg::frame_t frame;
    mrrc_pkg::capture_t capture;
    mrrc_pkg::check_t check;

    logic [mrrc_pkg::RegSlots-1:0][15:0] held_reg;
    logic [mrrc_pkg::RegSlots-1:0][15:0] held_next;
    logic out_valid_reg;
    mrrc_pkg::status_t status_reg;
    logic [7:0] length_reg;

    assign rx_words.ready = !out_valid_reg || results.ready;
    assign in_accept = rx_words.valid && rx_words.ready;
    assign frame_end = in_accept && (rx_words.command == mrrc_pkg::CMD_FRAME_END);

    mrrc_frame_acc #(
        .MAX_FRAME(MAX_FRAME)
    ) u_acc (
        .clk(clk),
        .rst_n(rst_n),
        .accept(in_accept),
        .command(rx_words.command),
        .rx_byte(rx_words.rx_byte),
        .frame(frame),
        .capture(capture)
    );

    mrrc_check u_check (
        .frame(frame),
        .capture(capture),
        .slave_address(slave_address_reg),
        .result(check)
    );

    always_comb
    begin
        held_next = held_reg;
        for (int k = 0; k < mrrc_pkg::RegSlots; k++)
        begin
            if (k < NUM_REGS && frame_end && check.load)
                held_next[k] = {capture[3 + 2 * k], capture[4 + 2 * k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= 8'd1;
            held_reg <= '0;
            out_valid_reg <= 1'b0;
            status_reg <= mrrc_pkg::STAT_OK;
            length_reg <= '0;
        end
        else
        begin
            if (cfg_write)
                slave_address_reg <= cfg_data;
            held_reg <= held_next;
            if (frame_end)
            begin
                out_valid_reg <= 1'b1;
                status_reg <= check.status;
                length_reg <= frame.count;
            end
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.status = status_reg;
    assign results.frame_length = length_reg;
    assign results.reg_zero = held_reg[0];
    assign results.reg_one = held_reg[1];
    assign results.reg_two = held_reg[2];
    assign results.reg_three = held_reg[3];
    assign results.reg_four = held_reg[4];

`ifndef NO_ASSERTIONS
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> out_valid_reg)
        else $error("frame end did not produce a result");

    a_end_clears_frame: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> (frame.count == '0 && frame.crc == mrrc_pkg::CrcInit))
        else $error("frame state not cleared after frame end");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> rx_words.ready)
        else $error("input stalled with empty result register");

    a_held_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(frame_end && check.load) |=> $stable(held_reg))
        else $error("held registers changed without a valid frame");

    a_short_status: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_end && frame.count < 8'd2) |=> status_reg == mrrc_pkg::STAT_SHORT)
        else $error("short frame not flagged");
`endif

endmodule

// ===== tb/tb_modbus_rtu_read_response_checker_core.sv =====
// Testbench for the Modbus RTU read response checker: queue-fed byte driver, result
// monitor and a cycle-level frame predictor. Depends on mrrc_pkg, mrrc_in_if, mrrc_out_if.
`timescale 1ns / 1ps

module tb_modbus_rtu_read_response_checker_core;

    localparam int MaxFrame = 255;
    localparam int NumRegs = 5;
    localparam int CycleLimit = 400000;

    typedef struct packed {
        logic command;
        logic [7:0] rx_byte;
    } rx_word_t;

    typedef struct packed {
        mrrc_pkg::status_t status;
        logic [7:0] frame_length;
        logic [mrrc_pkg::RegSlots-1:0][15:0] regs;
    } frame_result_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [7:0] cfg_data;

    mrrc_in_if rx_if ();
    mrrc_out_if res_if ();

    modbus_rtu_read_response_checker_core #(
        .MAX_FRAME(MaxFrame),
        .NUM_REGS(NumRegs)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data),
        .rx_words(rx_if),
        .results(res_if)
    );

    rx_word_t tx_words[$];
    frame_result_t pending_results[$];
    logic [7:0] frame_body[$];

    // predictor state
    logic [7:0] cap_bytes[mrrc_pkg::CapDepth];
    int byte_count;
    logic [15:0] run_crc;
    logic [7:0] tail_bytes[2];
    logic [15:0] held_regs[mrrc_pkg::RegSlots];
    logic [7:0] slave_addr;

    int errors;
    int cycles;
    int idle_pct;
    int words_queued;
    int words_taken;
    int frames_checked;
    int addr_settings;
    logic word_taken;
    rx_word_t drv_word;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (r[0])
                r = (r >> 1) ^ 16'hA001;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    task automatic clear_frame_state();
        byte_count = 0;
        run_crc = 16'hFFFF;
        tail_bytes[0] = 8'h00;
        tail_bytes[1] = 8'h00;
    endtask

    task automatic take_word(input logic cmd, input logic [7:0] b);
        frame_result_t r;
        logic [15:0] got;
        int hi;
        if (cmd == mrrc_pkg::CMD_BYTE)
        begin
            if (byte_count < MaxFrame)
            begin
                if (byte_count < mrrc_pkg::CapDepth)
                    cap_bytes[byte_count] = b;
                if (byte_count >= 2)
                    run_crc = crc16_update(run_crc, tail_bytes[0]);
                tail_bytes[0] = tail_bytes[1];
                tail_bytes[1] = b;
                byte_count++;
            end
        end
        else
        begin
            r.frame_length = 8'(byte_count);
            if (byte_count < 2)
                r.status = mrrc_pkg::STAT_SHORT;
            else
            begin
                got = {tail_bytes[1], tail_bytes[0]};
                if (got != run_crc)
                    r.status = mrrc_pkg::STAT_CRC_ERR;
                else if (cap_bytes[1] == mrrc_pkg::FuncRead && cap_bytes[0] == slave_addr)
                begin
                    for (int k = 0; k < NumRegs && k < mrrc_pkg::RegSlots; k++)
                    begin
                        hi = 3 + 2 * k;
                        if (hi + 1 < mrrc_pkg::CapDepth)
                            held_regs[k] = {cap_bytes[hi], cap_bytes[hi+1]};
                    end
                    r.status = mrrc_pkg::STAT_OK;
                end
                else
                    r.status = mrrc_pkg::STAT_NO_MATCH;
            end
            for (int k = 0; k < mrrc_pkg::RegSlots; k++)
                r.regs[k] = held_regs[k];
            clear_frame_state();
            pending_results.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            errors++;
        end
    endtask

    // monitor and predictor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            frame_result_t e;
            word_taken <= rx_if.valid && rx_if.ready;
            cycles <= cycles + 1;
            if (cycles > CycleLimit)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            if (res_if.valid && res_if.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with no expectation: status %0d length %0d",
                           res_if.status, res_if.frame_length);
                    errors++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    frames_checked++;
                    check_field("status", int'(e.status), int'(res_if.status));
                    check_field("frame_length", e.frame_length, res_if.frame_length);
                    check_field("reg_zero", e.regs[0], res_if.reg_zero);
                    check_field("reg_one", e.regs[1], res_if.reg_one);
                    check_field("reg_two", e.regs[2], res_if.reg_two);
                    check_field("reg_three", e.regs[3], res_if.reg_three);
                    check_field("reg_four", e.regs[4], res_if.reg_four);
                end
            end
            if (rx_if.valid && rx_if.ready)
            begin
                words_taken++;
                take_word(rx_if.command, rx_if.rx_byte);
            end
        end
    end

    // driver and result-side stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            res_if.ready <= ($urandom_range(99) >= idle_pct);
            if (!rx_if.valid || word_taken)
            begin
                if (tx_words.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    drv_word = tx_words.pop_front();
                    rx_if.valid <= 1'b1;
                    rx_if.command <= drv_word.command;
                    rx_if.rx_byte <= drv_word.rx_byte;
                end
                else
                    rx_if.valid <= 1'b0;
            end
        end
    end

    task automatic push_word(input logic cmd, input logic [7:0] b);
        rx_word_t w;
        w.command = cmd;
        w.rx_byte = b;
        tx_words.push_back(w);
        words_queued++;
    endtask

    task automatic push_end();
        push_word(mrrc_pkg::CMD_FRAME_END, 8'($urandom_range(255)));
    endtask

    // frame_body plus CRC (low byte first), then frame end
    task automatic send_frame(input bit bad_crc);
        logic [15:0] c;
        c = 16'hFFFF;
        foreach (frame_body[i])
        begin
            c = crc16_update(c, frame_body[i]);
            push_word(mrrc_pkg::CMD_BYTE, frame_body[i]);
        end
        if (bad_crc)
            c = c ^ (16'h1 << $urandom_range(15));
        push_word(mrrc_pkg::CMD_BYTE, c[7:0]);
        push_word(mrrc_pkg::CMD_BYTE, c[15:8]);
        push_end();
    endtask

    task automatic push_noise(input int n);
        for (int i = 0; i < n; i++)
            push_word(mrrc_pkg::CMD_BYTE, 8'($urandom_range(255)));
        push_end();
    endtask

    task automatic add_random_frame(input logic [7:0] addr);
        int sel;
        int n;
        sel = $urandom_range(99);
        frame_body.delete();
        if (sel < 75)
        begin
            frame_body.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : addr);
            frame_body.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                           : mrrc_pkg::FuncRead);
            n = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(10);
            frame_body.push_back(8'(n));
            for (int i = 0; i < n; i++)
                frame_body.push_back(8'($urandom_range(255)));
            send_frame(sel >= 60);
        end
        else if (sel < 90)
            push_noise($urandom_range(3));
        else
            push_noise($urandom_range(20, 4));
    endtask

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end while (tx_words.size() != 0 || rx_if.valid || pending_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_slave_address(input logic [7:0] v);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_data = v;
        @(negedge clk);
        cfg_write = 1'b0;
        slave_addr = v;
        addr_settings++;
        @(posedge clk);
    endtask

    task automatic run_random(input logic [7:0] addr, input int target);
        int start;
        start = words_queued;
        while (words_queued - start < target)
            add_random_frame(addr);
    endtask

    initial
    begin
        logic [7:0] phase_addr[4];
        errors = 0;
        cycles = 0;
        idle_pct = 37;
        words_queued = 0;
        words_taken = 0;
        frames_checked = 0;
        addr_settings = 1;
        word_taken = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = 8'h00;
        rx_if.valid = 1'b0;
        rx_if.command = mrrc_pkg::CMD_BYTE;
        rx_if.rx_byte = 8'h00;
        res_if.ready = 1'b0;
        foreach (cap_bytes[i])
            cap_bytes[i] = 8'h00;
        foreach (held_regs[i])
            held_regs[i] = 16'h0000;
        clear_frame_state();
        slave_addr = 8'h01;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed: empty and one-byte frames, two-byte frame, full reply, truncated reply
        push_end();
        push_word(mrrc_pkg::CMD_BYTE, 8'hFF);
        push_end();
        push_word(mrrc_pkg::CMD_BYTE, 8'hFF);
        push_word(mrrc_pkg::CMD_BYTE, 8'hFF);
        push_end();
        frame_body.delete();
        frame_body.push_back(8'h01);
        frame_body.push_back(mrrc_pkg::FuncRead);
        frame_body.push_back(8'd10);
        for (int i = 0; i < 10; i++)
            frame_body.push_back((i % 2) ? 8'hFF : 8'h00);
        send_frame(1'b0);
        frame_body.delete();
        frame_body.push_back(8'h01);
        frame_body.push_back(mrrc_pkg::FuncRead);
        send_frame(1'b0);
        run_random(8'h01, 60);
        wait_idle();

        phase_addr[0] = 8'h00;
        phase_addr[1] = 8'hFF;
        phase_addr[2] = 8'($urandom_range(255));
        phase_addr[3] = 8'h5A;
        for (int p = 0; p < 4; p++)
        begin
            write_slave_address(phase_addr[p]);
            idle_pct = (p == 2) ? 0 : 37;
            if (p == 2)
            begin
                // overlong reply: valid 255-byte frame, then bytes past the limit
                frame_body.delete();
                frame_body.push_back(phase_addr[p]);
                frame_body.push_back(mrrc_pkg::FuncRead);
                frame_body.push_back(8'd250);
                for (int i = 0; i < 250; i++)
                    frame_body.push_back(8'($urandom_range(255)));
                c_overlong: begin
                    logic [15:0] c;
                    c = 16'hFFFF;
                    foreach (frame_body[i])
                    begin
                        c = crc16_update(c, frame_body[i]);
                        push_word(mrrc_pkg::CMD_BYTE, frame_body[i]);
                    end
                    push_word(mrrc_pkg::CMD_BYTE, c[7:0]);
                    push_word(mrrc_pkg::CMD_BYTE, c[15:8]);
                end
                push_noise(40);
            end
            run_random(phase_addr[p], 35);
            wait_idle();
        end
        idle_pct = 37;

        wait_idle();
        repeat (10) @(posedge clk);
        $display("Checked %0d frames from %0d words under %0d slave-address settings,",
                 frames_checked, words_taken, addr_settings);
        $display("including short, truncated, overlong, bad-CRC and mismatched replies.");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
